// ===== rtl/sqllex_pkg.sv =====
`default_nettype none
package sqllex_pkg;

  localparam int LEN_BITS = 10;
  localparam int CFG_BITS = 10;
  localparam int MAX_RES  = 3;
  localparam int CNT_BITS = $clog2(MAX_RES + 1);
  localparam int IDX_BITS = $clog2(MAX_RES);

  localparam logic [LEN_BITS-1:0] LEN_SAT = {LEN_BITS{1'b1}};
  localparam logic [CFG_BITS-1:0] MAX_LEN_RST = CFG_BITS'(255);

  // token kinds given with the first byte
  localparam logic [1:0] TK_PLAIN = 2'd0;
  localparam logic [1:0] TK_STRIP = 2'd1;
  localparam logic [1:0] TK_OPER  = 2'd2;

  typedef enum logic [1:0] {
    RK_BYTE  = 2'd0,
    RK_END   = 2'd1,
    RK_DELIM = 2'd2,
    RK_EOT   = 2'd3
  } rkind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_CTRL   = 8'h20;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef struct packed {
    rkind_t              result_kind;
    logic [7:0]          out_byte;
    logic [LEN_BITS-1:0] tok_len;
    logic                too_long;
    logic                was_quoted;
    logic                last_result;
  } res_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]      n;
    res_t [MAX_RES-1:0]       res;
  } batch_t;

endpackage
`default_nettype wire

// ===== rtl/sqllex_in_if.sv =====
`default_nettype none
interface sqllex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;
  logic [1:0] token_kind;

  modport source (output valid, output char_byte, output end_of_text, output token_kind,
                  input ready);
  modport sink (input valid, input char_byte, input end_of_text, input token_kind,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/sqllex_out_if.sv =====
`default_nettype none
interface sqllex_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    result_kind;
  logic [7:0]                    out_byte;
  logic [sqllex_pkg::LEN_BITS-1:0] tok_len;
  logic                          too_long;
  logic                          was_quoted;
  logic                          last_result;

  modport source (output valid, output result_kind, output out_byte, output tok_len,
                  output too_long, output was_quoted, output last_result, input ready);
  modport sink (input valid, input result_kind, input out_byte, input tok_len,
                input too_long, input was_quoted, input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/sqllex_scan.sv =====
`default_nettype none
module sqllex_scan (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire logic [7:0]                      char_byte,
  input  wire logic                            end_of_text,
  input  wire logic [1:0]                      token_kind,
  input  wire logic                            cfg_we,
  input  wire logic [sqllex_pkg::CFG_BITS-1:0] cfg_wdata,
  output sqllex_pkg::batch_t                   batch
);
  import sqllex_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_COMMENT = 7'b0000010,
    PH_WORD    = 7'b0000100,
    PH_SQUOTE  = 7'b0001000,
    PH_DQKEEP  = 7'b0010000,
    PH_DQSTRIP = 7'b0100000,
    PH_OPER    = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t              ph;
    logic [1:0]          kd;
    logic [LEN_BITS-1:0] len;
    logic                over;
    logic                pend;
    logic [CNT_BITS-1:0] n;
    res_t [MAX_RES-1:0]  res;
  } work_t;

  phase_t              phase_r, phase_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic                over_r, over_nxt;
  logic                pend_r, pend_nxt;
  logic [CFG_BITS-1:0] maxlen_r;

  work_t w;
  logic  go_idle;
  logic  skip;
  logic  cls;

  function automatic logic is_ctrl(logic [7:0] c);
    return (c < CH_CTRL) || (c == CH_DEL);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return !is_ctrl(c) && (c != CH_SPACE) && (c != CH_COMMA) && (c != CH_LPAREN) &&
           (c != CH_RPAREN) && (c != CH_PIPE) && (c != CH_EQ) && (c != CH_BANG) &&
           (c != CH_GT) && (c != CH_LT);
  endfunction

  function automatic logic is_oper(logic [7:0] c);
    return !is_ctrl(c) && !((c >= CH_ZERO) && (c <= CH_NINE)) && (c != CH_SPACE) &&
           (c != CH_COMMA) && (c != CH_PIPE);
  endfunction

  function automatic logic is_tok(phase_t p);
    return (p == PH_WORD) || (p == PH_SQUOTE) || (p == PH_DQKEEP) ||
           (p == PH_DQSTRIP) || (p == PH_OPER);
  endfunction

  function automatic work_t f_put(work_t w_in, rkind_t k, logic [7:0] b,
                                  logic [LEN_BITS-1:0] l, logic too, logic q);
    work_t r;
    r = w_in;
    if (r.n < CNT_BITS'(MAX_RES)) begin
      r.res[r.n[IDX_BITS-1:0]] = '{result_kind: k, out_byte: b, tok_len: l,
                                   too_long: too, was_quoted: q, last_result: 1'b0};
      r.n = r.n + 1'b1;
    end
    return r;
  endfunction

  function automatic work_t f_take(work_t w_in, logic [7:0] c, logic [CFG_BITS-1:0] mx);
    work_t r;
    r = w_in;
    if ((r.len >= mx) || (r.len == LEN_SAT)) begin
      r.over = 1'b1;
    end else begin
      r = f_put(r, RK_BYTE, c, '0, 1'b0, 1'b0);
    end
    if (r.len != LEN_SAT) begin
      r.len = r.len + 1'b1;
    end
    return r;
  endfunction

  function automatic work_t f_finish(work_t w_in);
    work_t r;
    r = f_put(w_in, RK_END, CH_NUL, w_in.len, w_in.over, w_in.ph == PH_DQSTRIP);
    r.ph   = PH_IDLE;
    r.len  = '0;
    r.over = 1'b0;
    return r;
  endfunction

  function automatic work_t f_start(work_t w_in, logic [7:0] c, logic [1:0] k,
                                    logic [CFG_BITS-1:0] mx);
    work_t r;
    r = w_in;
    r.kd   = k;
    r.len  = '0;
    r.over = 1'b0;
    if (k == TK_OPER) begin
      if (is_oper(c)) begin
        r.ph = PH_OPER;
        r = f_take(r, c, mx);
      end else begin
        r = f_put(r, RK_DELIM, c, '0, 1'b0, 1'b0);
      end
    end else if (c == CH_SQUOTE) begin
      r.ph = PH_SQUOTE;
      r = f_take(r, c, mx);
    end else if (c == CH_DQUOTE) begin
      if (k == TK_STRIP) begin
        r.ph = PH_DQSTRIP;
      end else begin
        r.ph = PH_DQKEEP;
        r = f_take(r, c, mx);
      end
    end else if (is_word(c)) begin
      r.ph = PH_WORD;
      r = f_take(r, c, mx);
    end else begin
      r = f_put(r, RK_DELIM, c, '0, 1'b0, 1'b0);
    end
    return r;
  endfunction

  always_comb begin
    w      = '0;
    w.ph   = phase_r;
    w.kd   = kind_r;
    w.len  = len_r;
    w.over = over_r;
    w.pend = pend_r;
    go_idle = 1'b0;
    skip    = 1'b0;
    cls     = 1'b0;
    if (end_of_text || (char_byte == CH_NUL)) begin
      if (w.pend) begin
        w.pend = 1'b0;
        w = f_start(w, CH_DASH, w.kd, maxlen_r);
        w = f_finish(w);
      end else if (is_tok(w.ph)) begin
        w = f_finish(w);
      end
      w.ph   = PH_IDLE;
      w.len  = '0;
      w.over = 1'b0;
      w = f_put(w, RK_EOT, CH_NUL, '0, 1'b0, 1'b0);
    end else if (w.ph == PH_COMMENT) begin
      if (char_byte == CH_NL) begin
        w.ph = PH_IDLE;
      end
    end else begin
      unique case (w.ph)
        PH_WORD: begin
          if (is_word(char_byte)) begin
            w = f_take(w, char_byte, maxlen_r);
          end else begin
            w = f_finish(w);
            go_idle = 1'b1;
          end
        end
        PH_OPER: begin
          if (is_oper(char_byte)) begin
            w = f_take(w, char_byte, maxlen_r);
          end else begin
            w = f_finish(w);
            go_idle = 1'b1;
          end
        end
        PH_SQUOTE: begin
          w = f_take(w, char_byte, maxlen_r);
          if (char_byte == CH_SQUOTE) w = f_finish(w);
        end
        PH_DQKEEP: begin
          w = f_take(w, char_byte, maxlen_r);
          if (char_byte == CH_DQUOTE) w = f_finish(w);
        end
        PH_DQSTRIP: begin
          if (char_byte == CH_DQUOTE) w = f_finish(w);
          else w = f_take(w, char_byte, maxlen_r);
        end
        default: begin
          w.ph = PH_IDLE;
          go_idle = 1'b1;
        end
      endcase
      if (go_idle) begin
        if (w.pend) begin
          w.pend = 1'b0;
          if (char_byte == CH_DASH) begin
            w.ph = PH_COMMENT;
            skip = 1'b1;
          end else begin
            // held dash opens a token, which this byte continues if it fits the token's class
            w = f_start(w, CH_DASH, w.kd, maxlen_r);
            cls = (w.ph == PH_OPER) ? is_oper(char_byte) : is_word(char_byte);
            if (cls) begin
              w = f_take(w, char_byte, maxlen_r);
              skip = 1'b1;
            end else begin
              w = f_finish(w);
            end
          end
        end
        if (!skip) begin
          if (is_space(char_byte)) begin
            w.ph = w.ph;
          end else if (char_byte == CH_DASH) begin
            w.pend = 1'b1;
            w.kd   = token_kind;
          end else begin
            w = f_start(w, char_byte, token_kind, maxlen_r);
          end
        end
      end
    end
    if (w.n != '0) begin
      w.res[IDX_BITS'(w.n - 1'b1)].last_result = 1'b1;
    end
  end

  assign phase_nxt = w.ph;
  assign kind_nxt  = w.kd;
  assign len_nxt   = w.len;
  assign over_nxt  = w.over;
  assign pend_nxt  = w.pend;
  assign batch     = '{n: w.n, res: w.res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      kind_r   <= TK_PLAIN;
      len_r    <= '0;
      over_r   <= 1'b0;
      pend_r   <= 1'b0;
      maxlen_r <= MAX_LEN_RST;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        len_r   <= len_nxt;
        over_r  <= over_nxt;
        pend_r  <= pend_nxt;
      end
      if (cfg_we) begin
        maxlen_r <= cfg_wdata;
      end
    end
  end

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (phase_r == PH_IDLE))
    else $error("held dash outside idle phase");

  a_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !is_tok(phase_r) |-> ((len_r == '0) && !over_r))
    else $error("length state left over between tokens");

  a_comment_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (phase_r == PH_COMMENT) && !end_of_text && (char_byte != CH_NUL))
      |-> (batch.n == '0))
    else $error("comment byte produced a word");

endmodule
`default_nettype wire

// ===== rtl/sqllex_emit.sv =====
`default_nettype none
module sqllex_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire sqllex_pkg::batch_t batch,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output sqllex_pkg::res_t        head,
  output logic                    free
);
  import sqllex_pkg::*;

  res_t [MAX_RES-1:0]  q_r, q_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_fire;

  assign out_valid = (cnt_r != '0);
  assign head      = q_r[0];
  assign out_fire  = out_valid && out_ready;
  // room for a new batch once the last queued word leaves
  assign free      = (cnt_r == '0) || ((cnt_r == CNT_BITS'(1)) && out_ready);

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load) begin
      q_nxt   = batch.res;
      cnt_nxt = batch.n;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_last_one: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_BITS'(1)) |-> q_r[0].last_result)
    else $error("final word lacks last flag");

  a_last_two: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_BITS'(2)) |-> (q_r[1].last_result && !q_r[0].last_result))
    else $error("last flag misplaced in queue");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (batch.n != '0)) |=> out_valid)
    else $error("loaded batch not presented");

endmodule
`default_nettype wire

// ===== rtl/sqllex_out_drv.sv =====
`default_nettype none
module sqllex_out_drv (
  input  wire logic             valid,
  input  wire sqllex_pkg::res_t head,
  output logic                  ready,
  sqllex_out_if.source          out_ch
);
  import sqllex_pkg::*;

  assign out_ch.valid        = valid;
  assign out_ch.result_kind  = head.result_kind;
  assign out_ch.out_byte     = (head.result_kind == RK_BYTE || head.result_kind == RK_DELIM)
                               ? head.out_byte : CH_NUL;
  assign out_ch.tok_len      = head.tok_len;
  assign out_ch.too_long     = head.too_long;
  assign out_ch.was_quoted   = head.was_quoted;
  assign out_ch.last_result  = head.last_result;
  assign ready               = out_ch.ready;

endmodule
`default_nettype wire

// ===== rtl/sql_token_lexer_top.sv =====
// output: first result word is offered in the cycle after its input word is accepted
// throughput: one input word per cycle while out_ready is high and each word yields at
//   most one result; a word yielding more (up to 3) holds input until its last leaves
// reset: synchronous, active low; scan state returns to between tokens, queue empties,
//   max_token_length returns to 255
`default_nettype none
module sql_token_lexer_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  sqllex_in_if.sink                            in_ch,
  sqllex_out_if.source                         out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [sqllex_pkg::CFG_BITS-1:0] cfg_wdata
);
  import sqllex_pkg::*;

  batch_t batch;
  res_t   head;
  logic   free;
  logic   in_fire;
  logic   em_valid;
  logic   em_ready;

  assign in_ch.ready = free;
  assign in_fire     = in_ch.valid && free;

  sqllex_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .char_byte   (in_ch.char_byte),
    .end_of_text (in_ch.end_of_text),
    .token_kind  (in_ch.token_kind),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .batch       (batch)
  );

  sqllex_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .batch     (batch),
    .out_ready (em_ready),
    .out_valid (em_valid),
    .head      (head),
    .free      (free)
  );

  sqllex_out_drv u_out (
    .valid  (em_valid),
    .head   (head),
    .ready  (em_ready),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ===== bench/lex_checker.sv =====
`timescale 1ns / 1ps
module lex_checker
  import sqllex_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  sqllex_in_if                in_ch,
  sqllex_out_if               out_ch,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  output int                  pending_cnt,
  output int                  fail_cnt
);

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_COMMENT,
    SP_WORD,
    SP_SQUOTE,
    SP_DQKEEP,
    SP_DQSTRIP,
    SP_OPER
  } scan_t;

  scan_t               phase;
  logic [1:0]          run_kind;
  logic [LEN_BITS-1:0] run_len;
  bit                  dash_held;
  bit                  dropped;
  logic [CFG_BITS-1:0] max_len;
  int                  words_seen;

  res_t step_words[$];
  res_t lexed_words[$];

  function automatic bit ctrl_char(logic [7:0] c);
    return c < CH_CTRL || c == CH_DEL;
  endfunction

  function automatic bit blank_char(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return !ctrl_char(c) && !(c inside {CH_SPACE, CH_COMMA, CH_LPAREN, CH_RPAREN, CH_PIPE,
                                        CH_EQ, CH_BANG, CH_GT, CH_LT});
  endfunction

  function automatic bit oper_char(logic [7:0] c);
    return !ctrl_char(c) && !(c >= CH_ZERO && c <= CH_NINE) &&
           !(c inside {CH_SPACE, CH_COMMA, CH_PIPE});
  endfunction

  function automatic bit in_run();
    return phase inside {SP_WORD, SP_SQUOTE, SP_DQKEEP, SP_DQSTRIP, SP_OPER};
  endfunction

  function automatic void emit(rkind_t rk, logic [7:0] b, logic [LEN_BITS-1:0] n, bit tl,
                               bit q);
    res_t r;
    r.result_kind  = rk;
    r.out_byte     = b;
    r.tok_len      = n;
    r.too_long     = tl;
    r.was_quoted   = q;
    r.last_result  = 1'b0;
    step_words.push_back(r);
  endfunction

  function automatic void take_byte(logic [7:0] c);
    if (run_len >= max_len || run_len == LEN_SAT) dropped = 1'b1;
    else emit(RK_BYTE, c, '0, 1'b0, 1'b0);
    if (run_len != LEN_SAT) run_len++;
  endfunction

  function automatic void close_run();
    emit(RK_END, CH_NUL, run_len, dropped, phase == SP_DQSTRIP);
    phase   = SP_IDLE;
    run_len = '0;
    dropped = 1'b0;
  endfunction

  function automatic void open_run(logic [7:0] c, logic [1:0] k);
    run_kind = k;
    run_len  = '0;
    dropped  = 1'b0;
    if (k == TK_OPER) begin
      if (oper_char(c)) begin
        phase = SP_OPER;
        take_byte(c);
      end else emit(RK_DELIM, c, '0, 1'b0, 1'b0);
    end else if (c == CH_SQUOTE) begin
      phase = SP_SQUOTE;
      take_byte(c);
    end else if (c == CH_DQUOTE) begin
      if (k == TK_STRIP) phase = SP_DQSTRIP;
      else begin
        phase = SP_DQKEEP;
        take_byte(c);
      end
    end else if (word_char(c)) begin
      phase = SP_WORD;
      take_byte(c);
    end else emit(RK_DELIM, c, '0, 1'b0, 1'b0);
  endfunction

  // returns 0 when the token ended without consuming c
  function automatic bit run_byte(logic [7:0] c);
    bit used;
    used = 1'b1;
    case (phase)
      SP_WORD: begin
        if (word_char(c)) take_byte(c);
        else begin
          close_run();
          used = 1'b0;
        end
      end
      SP_OPER: begin
        if (oper_char(c)) take_byte(c);
        else begin
          close_run();
          used = 1'b0;
        end
      end
      SP_SQUOTE: begin
        take_byte(c);
        if (c == CH_SQUOTE) close_run();
      end
      SP_DQKEEP: begin
        take_byte(c);
        if (c == CH_DQUOTE) close_run();
      end
      SP_DQSTRIP: begin
        if (c == CH_DQUOTE) close_run();
        else take_byte(c);
      end
      default: used = 1'b0;
    endcase
    return used;
  endfunction

  function automatic void idle_byte(logic [7:0] c, logic [1:0] k);
    if (dash_held) begin
      dash_held = 1'b0;
      if (c == CH_DASH) begin
        phase = SP_COMMENT;
        return;
      end
      open_run(CH_DASH, run_kind);
      if (run_byte(c)) return;
    end
    if (blank_char(c)) return;
    if (c == CH_DASH) begin
      dash_held = 1'b1;
      run_kind  = k;
      return;
    end
    open_run(c, k);
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic eot, logic [1:0] k);
    step_words.delete();
    if (eot || c == CH_NUL) begin
      if (dash_held) begin
        dash_held = 1'b0;
        open_run(CH_DASH, run_kind);
        close_run();
      end else if (in_run()) close_run();
      phase   = SP_IDLE;
      run_len = '0;
      dropped = 1'b0;
      emit(RK_EOT, CH_NUL, '0, 1'b0, 1'b0);
    end else if (phase == SP_COMMENT) begin
      if (c == CH_NL) phase = SP_IDLE;
    end else if (in_run()) begin
      if (!run_byte(c)) idle_byte(c, k);
    end else begin
      phase = SP_IDLE;
      idle_byte(c, k);
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last_result = 1'b1;
    foreach (step_words[i]) lexed_words.push_back(step_words[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    fail_cnt++;
    $display("mismatch at result word %0d: %s", words_seen, msg);
  endtask

  task automatic check_word();
    res_t got;
    res_t want;
    got.result_kind  = rkind_t'(out_ch.result_kind);
    got.out_byte     = out_ch.out_byte;
    got.tok_len      = out_ch.tok_len;
    got.too_long     = out_ch.too_long;
    got.was_quoted   = out_ch.was_quoted;
    got.last_result  = out_ch.last_result;
    if (lexed_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind %0d byte %02h", got.result_kind,
                                got.out_byte));
    end else begin
      want = lexed_words.pop_front();
      if (got.result_kind !== want.result_kind || got.out_byte !== want.out_byte ||
          got.tok_len !== want.tok_len || got.too_long !== want.too_long ||
          got.was_quoted !== want.was_quoted || got.last_result !== want.last_result) begin
        report_mismatch($sformatf(
          "got kind %0d byte %02h len %0d long %b quoted %b last %b, want %0d %02h %0d %b %b %b",
          got.result_kind, got.out_byte, got.tok_len, got.too_long, got.was_quoted,
          got.last_result, want.result_kind, want.out_byte, want.tok_len,
          want.too_long, want.was_quoted, want.last_result));
      end
    end
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = SP_IDLE;
      run_kind   = TK_PLAIN;
      run_len    = '0;
      dash_held  = 1'b0;
      dropped    = 1'b0;
      max_len    = MAX_LEN_RST;
      words_seen = 0;
      fail_cnt   = 0;
      lexed_words.delete();
    end else begin
      if (cfg_we) max_len = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        lex_byte(in_ch.char_byte, in_ch.end_of_text, in_ch.token_kind);
      if (out_ch.valid && out_ch.ready) check_word();
    end
    pending_cnt <= lexed_words.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sqllex_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_WORDS = 410;
  localparam string OPS       = "=<>!+*/%&^~.;:()?@#$";

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;
  int                  pending_cnt;
  int                  fail_cnt;

  int burst_left = 0;
  bit steady     = 1'b0;
  int words_sent = 0;
  int idle_cycles = 0;
  int rx_mode    = 0;
  int hold_left  = 0;
  int rx_cycle   = 0;

  sqllex_in_if  in_ch();
  sqllex_out_if out_ch();

  sql_token_lexer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lex_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pending_cnt (pending_cnt),
    .fail_cnt    (fail_cnt)
  );

  always #4 clk = ~clk;

  // receiver stalls, in one of three patterns that rx_mode selects and rx_cycle re-picks
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 255) rx_mode <= $urandom_range(0, 2);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 3) == 0) hold_left <= $urandom_range(1, 3);
      else if (rx_mode == 2 && $urandom_range(0, 1) == 0) hold_left <= $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_word(input logic [7:0] c, input logic eot, input logic [1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 :
            ($urandom_range(0, 9) == 0 ? $urandom_range(8, 20) : $urandom_range(0, 4));
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.char_byte   <= c;
    in_ch.end_of_text <= eot;
    in_ch.token_kind  <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s, input logic [1:0] k);
    foreach (s[i]) send_word(s[i], 1'b0, k);
  endtask

  // hold the sender until every expected word is out
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [CFG_BITS-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [1:0] kind_pick();
    return ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] word_pick();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(128, 255));
      1: return 8'($urandom_range(CH_ZERO, CH_NINE));
      default: return 8'($urandom_range(8'h41, 8'h7A));
    endcase
  endfunction

  function automatic logic [7:0] body_pick(input logic [7:0] stop);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == stop);
    return c;
  endfunction

  function automatic logic [7:0] blank_pick();
    int r;
    r = $urandom_range(CH_TAB, CH_CR + 1);
    return (r == CH_CR + 1) ? CH_SPACE : 8'(r);
  endfunction

  function automatic logic [7:0] delim_pick();
    case ($urandom_range(0, 5))
      0: return CH_COMMA;
      1: return CH_PIPE;
      2: return 8'($urandom_range(1, CH_TAB - 1));
      3: return 8'($urandom_range(CH_CR + 1, CH_CTRL - 1));
      4: return CH_DEL;
      default: begin
        case ($urandom_range(0, 5))
          0: return CH_LPAREN;
          1: return CH_RPAREN;
          2: return CH_EQ;
          3: return CH_BANG;
          4: return CH_LT;
          default: return CH_GT;
        endcase
      end
    endcase
  endfunction

  task automatic send_group();
    int n;
    n = $urandom_range(1, 7);
    case ($urandom_range(0, 11))
      0, 1: repeat (n) send_word(word_pick(), 1'b0, kind_pick());
      2: begin
        send_word(blank_pick(), 1'b0, kind_pick());
        send_word(CH_SQUOTE, 1'b0, kind_pick());
        repeat (n - 1) send_word(body_pick(CH_SQUOTE), 1'b0, kind_pick());
        send_word(CH_SQUOTE, 1'b0, kind_pick());
      end
      3: begin
        send_word(blank_pick(), 1'b0, kind_pick());
        send_word(CH_DQUOTE, 1'b0, $urandom_range(0, 1) ? TK_STRIP : TK_PLAIN);
        repeat (n - 1) send_word(body_pick(CH_DQUOTE), 1'b0, kind_pick());
        send_word(CH_DQUOTE, 1'b0, kind_pick());
      end
      4: begin
        send_word(OPS[$urandom_range(0, OPS.len() - 1)], 1'b0, TK_OPER);
        repeat (n - 1) send_word(OPS[$urandom_range(0, OPS.len() - 1)], 1'b0, kind_pick());
      end
      5: begin
        send_word(blank_pick(), 1'b0, kind_pick());
        send_word(CH_DASH, 1'b0, kind_pick());
        send_word(CH_DASH, 1'b0, kind_pick());
        repeat (n) send_word(body_pick(CH_NL), 1'b0, kind_pick());
        send_word(CH_NL, 1'b0, kind_pick());
      end
      6: repeat ($urandom_range(1, 3)) send_word(blank_pick(), 1'b0, kind_pick());
      7: send_word(delim_pick(), 1'b0, kind_pick());
      8: begin
        send_word(blank_pick(), 1'b0, kind_pick());
        send_word(CH_DASH, 1'b0, kind_pick());
        send_word(8'($urandom_range(1, 255)), 1'b0, kind_pick());
      end
      9: send_word(8'($urandom_range(0, 255)), 1'b1, kind_pick());
      10: repeat (n)
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0, kind_pick());
      default: send_word(CH_NUL, 1'b0, kind_pick());
    endcase
  endtask

  initial begin
    int base;
    int phase_no;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.char_byte   = '0;
    in_ch.end_of_text = 1'b0;
    in_ch.token_kind  = TK_PLAIN;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_text("ab,", TK_PLAIN);
    send_text("'x'", TK_PLAIN);
    send_text("\"q\"", TK_STRIP);
    send_text("\"\"", TK_STRIP);
    send_text("\"k\"", TK_PLAIN);
    send_text(">=9", TK_OPER);
    send_text("--c\n", TK_PLAIN);
    send_text("-a", TK_OPER);
    send_word(8'hFF, 1'b0, 2'd3);
    send_word(CH_NUL, 1'b0, TK_PLAIN);
    send_word(8'h80, 1'b0, 2'd3);
    send_word(CH_DEL, 1'b0, TK_PLAIN);
    send_word(8'h01, 1'b0, TK_OPER);
    send_text("-", TK_PLAIN);
    send_word(8'h5A, 1'b1, TK_PLAIN);
    send_text("'z", TK_PLAIN);
    send_word(CH_NUL, 1'b1, TK_PLAIN);
    write_max_len('0);
    send_text("ab ", TK_PLAIN);

    base     = words_sent;
    phase_no = 0;
    while (words_sent - base < RANDOM_WORDS) begin
      case (phase_no)
        0: write_max_len(CFG_BITS'(1023));
        1: write_max_len(CFG_BITS'(1));
        2: write_max_len(CFG_BITS'(3));
        3: write_max_len('0);
        default: write_max_len($urandom_range(0, 1) ? CFG_BITS'($urandom_range(0, 1023)) :
                                                      CFG_BITS'($urandom_range(2, 12)));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 18)) send_group();
      phase_no++;
    end

    // one token well past the length limit
    write_max_len(CFG_BITS'(5));
    steady = 1'b0;
    send_word(CH_SPACE, 1'b0, TK_PLAIN);
    repeat (20) send_word(word_pick(), 1'b0, TK_PLAIN);
    send_word(CH_SPACE, 1'b0, TK_PLAIN);
    send_word(CH_NUL, 1'b1, TK_PLAIN);

    settle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
